>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

>>> rtl/uer_pkg.sv
// Types and constants of the ultrasonic echo ranger
`default_nettype none
package uer_pkg;

    localparam int SENSORS      = 3;
    localparam int CH_BITS      = 2;
    localparam int STAMP_BITS   = 16;
    localparam int TIMEOUT_BITS = 8;
    localparam int TICK_BITS    = 16;
    localparam int NSCM_BITS    = 20;
    localparam int DIST_BITS    = 16;
    localparam int CFG_BITS     = 20;
    localparam int CFG_IDX_BITS = 2;
    localparam int WIDTH_BITS   = STAMP_BITS + 1;
    localparam int PROD_BITS    = WIDTH_BITS + TICK_BITS;
    localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);
    localparam int QDEPTH       = 2;
    localparam int QPTR_BITS    = 1;
    localparam int QCNT_BITS    = 2;

    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic KIND_TRIGGER = 1'b0;
    localparam logic KIND_RANGE   = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ECHO_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COUNTER_WRAP = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_NS      = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NS_PER_CM    = 2'd3;

    localparam logic [TIMEOUT_BITS-1:0] RST_ECHO_TIMEOUT = 8'd20;
    localparam logic [STAMP_BITS-1:0]   RST_COUNTER_WRAP = 16'hBFFF;
    localparam logic [TICK_BITS-1:0]    RST_TICK_NS      = 16'd2667;
    localparam logic [NSCM_BITS-1:0]    RST_NS_PER_CM    = 20'd58000;

    typedef struct packed {
        logic                  action;
        logic [CH_BITS-1:0]    channel;
        logic [STAMP_BITS-1:0] stamp;
    } cmd_t;

    typedef struct packed {
        logic [CH_BITS-1:0]   sensor;
        logic                 kind;
        logic [DIST_BITS-1:0] distance_cm;
        logic                 last;
    } res_t;

    typedef struct packed {
        logic [SENSORS-1:0]                 trig;
        logic [SENSORS-1:0]                 meas;
        logic [SENSORS-1:0][WIDTH_BITS-1:0] pulse_width;
    } job_t;

endpackage
`default_nettype wire

>>> rtl/uer_queue.sv
// Two-entry queue of tick jobs between front and back
`default_nettype none
module uer_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire uer_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               avail,
    output uer_pkg::job_t      pop_job
);

    uer_pkg::job_t                      mem_reg [uer_pkg::QDEPTH];
    logic [uer_pkg::QPTR_BITS-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [uer_pkg::QPTR_BITS-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [uer_pkg::QCNT_BITS-1:0]      count_reg, count_next;
    logic                               do_push, do_pop;

    assign full    = (count_reg == uer_pkg::QCNT_BITS'(uer_pkg::QDEPTH));
    assign avail   = (count_reg != '0);
    assign pop_job = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

>>> rtl/uer_front.sv
// Front end: channel state, edge capture and tick classification
`default_nettype none
module uer_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cmd_valid,
    output logic                                     cmd_ready,
    input  wire uer_pkg::cmd_t                       cmd,
    input  wire logic [uer_pkg::TIMEOUT_BITS-1:0]    echo_timeout,
    input  wire logic [uer_pkg::STAMP_BITS-1:0]      counter_wrap,
    input  wire logic                                queue_full,
    output logic                                     job_push,
    output uer_pkg::job_t                            job
);

    logic [uer_pkg::STAMP_BITS-1:0]   rise_reg  [uer_pkg::SENSORS];
    logic [uer_pkg::STAMP_BITS-1:0]   rise_next [uer_pkg::SENSORS];
    logic [uer_pkg::STAMP_BITS-1:0]   fall_reg  [uer_pkg::SENSORS];
    logic [uer_pkg::STAMP_BITS-1:0]   fall_next [uer_pkg::SENSORS];
    logic [uer_pkg::TIMEOUT_BITS-1:0] wait_reg  [uer_pkg::SENSORS];
    logic [uer_pkg::TIMEOUT_BITS-1:0] wait_next [uer_pkg::SENSORS];
    logic [uer_pkg::SENSORS-1:0]      expect_rise_reg, expect_rise_next;
    logic [uer_pkg::SENSORS-1:0]      pending_reg, pending_next;
    logic [uer_pkg::SENSORS-1:0]      waiting_reg, waiting_next;
    logic [uer_pkg::WIDTH_BITS:0]     wrapped [uer_pkg::SENSORS];
    logic                             accept;

    assign cmd_ready = !queue_full;
    assign accept    = cmd_valid && cmd_ready;

    always_comb
    begin
        for (int i = 0; i < uer_pkg::SENSORS; i++)
        begin
            rise_next[i] = rise_reg[i];
            fall_next[i] = fall_reg[i];
            wait_next[i] = wait_reg[i];
            wrapped[i]   = {2'b00, counter_wrap} - {2'b00, rise_reg[i]} + {2'b00, fall_reg[i]};
        end
        expect_rise_next = expect_rise_reg;
        pending_next     = pending_reg;
        waiting_next     = waiting_reg;
        job_push         = 1'b0;
        job.trig         = '0;
        job.meas         = '0;
        for (int i = 0; i < uer_pkg::SENSORS; i++)
        begin
            if (fall_reg[i] > rise_reg[i])
            begin
                job.pulse_width[i] = {1'b0, fall_reg[i] - rise_reg[i]};
            end
            else if (wrapped[i][uer_pkg::WIDTH_BITS])
            begin
                job.pulse_width[i] = '0;
            end
            else
            begin
                job.pulse_width[i] = wrapped[i][uer_pkg::WIDTH_BITS-1:0];
            end
        end
        if (accept)
        begin
            if (cmd.action == uer_pkg::ACT_EDGE)
            begin
                if (int'(cmd.channel) < uer_pkg::SENSORS)
                begin
                    if (expect_rise_reg[cmd.channel])
                    begin
                        rise_next[cmd.channel]        = cmd.stamp;
                        expect_rise_next[cmd.channel] = 1'b0;
                    end
                    else
                    begin
                        fall_next[cmd.channel]        = cmd.stamp;
                        expect_rise_next[cmd.channel] = 1'b1;
                        pending_next[cmd.channel]     = 1'b1;
                    end
                end
            end
            else
            begin
                for (int i = 0; i < uer_pkg::SENSORS; i++)
                begin
                    if (!waiting_reg[i] || wait_reg[i] == echo_timeout)
                    begin
                        job.trig[i]         = 1'b1;
                        waiting_next[i]     = 1'b1;
                        expect_rise_next[i] = 1'b1;
                        wait_next[i]        = '0;
                    end
                    else if (pending_reg[i])
                    begin
                        job.meas[i]     = 1'b1;
                        pending_next[i] = 1'b0;
                        waiting_next[i] = 1'b0;
                    end
                    else
                    begin
                        wait_next[i] = wait_reg[i] + 1'b1;
                    end
                end
                job_push = ((job.trig | job.meas) != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < uer_pkg::SENSORS; i++)
            begin
                rise_reg[i] <= '0;
                fall_reg[i] <= '0;
                wait_reg[i] <= '0;
            end
            expect_rise_reg <= '1;
            pending_reg     <= '0;
            waiting_reg     <= '0;
        end
        else
        begin
            for (int i = 0; i < uer_pkg::SENSORS; i++)
            begin
                rise_reg[i] <= rise_next[i];
                fall_reg[i] <= fall_next[i];
                wait_reg[i] <= wait_next[i];
            end
            expect_rise_reg <= expect_rise_next;
            pending_reg     <= pending_next;
            waiting_reg     <= waiting_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/uer_div.sv
// Restoring divider, one quotient bit per cycle
`default_nettype none
module uer_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [uer_pkg::PROD_BITS-1:0]    dividend,
    input  wire logic [uer_pkg::NSCM_BITS-1:0]    divisor,
    output logic                                  done,
    output logic [uer_pkg::PROD_BITS-1:0]         quotient
);

    logic [uer_pkg::PROD_BITS-1:0]    quo_reg, quo_next;
    logic [uer_pkg::NSCM_BITS-1:0]    rem_reg, rem_next;
    logic [uer_pkg::DIV_CNT_BITS-1:0] count_reg, count_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [uer_pkg::NSCM_BITS:0]      rem_shift;
    logic [uer_pkg::NSCM_BITS:0]      rem_diff;
    logic                             fits;

    assign rem_shift = {rem_reg, quo_reg[uer_pkg::PROD_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};
    assign fits      = (rem_shift >= {1'b0, divisor});
    assign done      = done_reg;
    assign quotient  = quo_reg;

    always_comb
    begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            quo_next   = dividend;
            rem_next   = '0;
            count_next = uer_pkg::DIV_CNT_BITS'(uer_pkg::PROD_BITS);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next   = {quo_reg[uer_pkg::PROD_BITS-2:0], fits};
            rem_next   = fits ? rem_diff[uer_pkg::NSCM_BITS-1:0]
                              : rem_shift[uer_pkg::NSCM_BITS-1:0];
            count_next = count_reg - 1'b1;
            if (count_reg == uer_pkg::DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule
`default_nettype wire

>>> rtl/uer_back.sv
// Back end: walks a tick job per channel and issues result items
`default_nettype none
module uer_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             job_avail,
    input  wire uer_pkg::job_t                    job,
    output logic                                  job_pop,
    input  wire logic [uer_pkg::TICK_BITS-1:0]    tick_ns,
    input  wire logic [uer_pkg::NSCM_BITS-1:0]    ns_per_cm,
    output logic                                  res_valid,
    input  wire logic                             res_ready,
    output uer_pkg::res_t                         res,
    output logic                                  busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                                state_reg, state_next;
    logic [uer_pkg::CH_BITS-1:0]               ch_reg, ch_next;
    logic [uer_pkg::SENSORS-1:0]               trig_reg, trig_next;
    logic [uer_pkg::SENSORS-1:0]               dist_reg, dist_next;
    logic [uer_pkg::SENSORS-1:0][uer_pkg::WIDTH_BITS-1:0] width_reg, width_next;
    logic [uer_pkg::PROD_BITS-1:0]             prod_reg, prod_next;
    logic                                      out_valid_reg, out_valid_next;
    uer_pkg::res_t                             out_reg, out_next;
    logic [uer_pkg::SENSORS-1:0]               ch_bit;
    logic [uer_pkg::SENSORS-1:0]               rest_mask;
    logic                                      div_start;
    logic                                      div_done;
    logic [uer_pkg::PROD_BITS-1:0]             div_quo;
    logic [uer_pkg::DIST_BITS-1:0]             dist_sat;

    uer_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (ns_per_cm),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign busy      = (state_reg != S_IDLE);
    assign div_start = (state_reg == S_MUL);
    assign ch_bit    = uer_pkg::SENSORS'(1) << ch_reg;
    assign rest_mask = (trig_reg | dist_reg) & ~ch_bit;
    assign dist_sat  = (div_quo[uer_pkg::PROD_BITS-1:uer_pkg::DIST_BITS] != '0)
                       ? '1 : div_quo[uer_pkg::DIST_BITS-1:0];

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        trig_next      = trig_reg;
        dist_next      = dist_reg;
        width_next     = width_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        job_pop        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (job_avail)
                begin
                    job_pop    = 1'b1;
                    trig_next  = job.trig;
                    dist_next  = job.meas;
                    width_next = job.pulse_width;
                    ch_next    = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (trig_reg[ch_reg])
                begin
                    out_next.sensor      = ch_reg;
                    out_next.kind        = uer_pkg::KIND_TRIGGER;
                    out_next.distance_cm = '0;
                    out_next.last        = (rest_mask == '0);
                    out_valid_next       = 1'b1;
                    state_next           = S_OUT;
                end
                else if (dist_reg[ch_reg])
                begin
                    prod_next  = uer_pkg::PROD_BITS'(width_reg[ch_reg])
                                 * uer_pkg::PROD_BITS'(tick_ns);
                    state_next = S_MUL;
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    out_next.sensor      = ch_reg;
                    out_next.kind        = uer_pkg::KIND_RANGE;
                    out_next.distance_cm = dist_sat;
                    out_next.last        = (rest_mask == '0);
                    out_valid_next       = 1'b1;
                    state_next           = S_OUT;
                end
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    out_valid_next = 1'b0;
                    trig_next      = trig_reg & ~ch_bit;
                    dist_next      = dist_reg & ~ch_bit;
                    ch_next        = ch_reg + 1'b1;
                    state_next     = (rest_mask == '0) ? S_IDLE : S_SCAN;
                end
            end
            default:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            trig_reg      <= '0;
            dist_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            trig_reg      <= trig_next;
            dist_reg      <= dist_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg <= width_next;
        prod_reg  <= prod_next;
        out_reg   <= out_next;
    end

endmodule
`default_nettype wire

>>> rtl/ultrasonic_echo_ranger.sv
// Top level of the three-channel ultrasonic echo ranger
//
//  channel  signals                          item
//  cmd      cmd_valid / cmd_ready / cmd      echo edge or period tick
//  res      res_valid / res_ready / res      trigger request or distance
//  cfg      cfg_we / cfg_index / cfg_data    register write, no handshake
//
//  An edge updates the channel state in the front end; a tick is classified there and queued.
//  The back end walks a job channel by channel: a trigger is issued directly, a
//  distance runs a 33-step restoring divider; each result waits on res_ready.
//  The two-entry job queue lets the front end keep taking items while the
//  back end stalls; cmd_ready drops only when the queue is full.
//  Reset is asynchronous; all channels start untriggered and expecting a rise.
`default_nettype none
`include "assert_macros.svh"
module ultrasonic_echo_ranger (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cmd_valid,
    output logic                                    cmd_ready,
    input  wire uer_pkg::cmd_t                      cmd,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output uer_pkg::res_t                           res,
    input  wire logic                               cfg_we,
    input  wire logic [uer_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [uer_pkg::CFG_BITS-1:0]       cfg_data
);

    logic [uer_pkg::TIMEOUT_BITS-1:0] timeout_reg;
    logic [uer_pkg::STAMP_BITS-1:0]   wrap_reg;
    logic [uer_pkg::TICK_BITS-1:0]    tick_reg;
    logic [uer_pkg::NSCM_BITS-1:0]    nscm_reg;
    logic                             queue_full;
    logic                             job_push;
    uer_pkg::job_t                    push_job;
    logic                             job_avail;
    logic                             job_pop;
    uer_pkg::job_t                    pop_job;
    logic                             back_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= uer_pkg::RST_ECHO_TIMEOUT;
            wrap_reg    <= uer_pkg::RST_COUNTER_WRAP;
            tick_reg    <= uer_pkg::RST_TICK_NS;
            nscm_reg    <= uer_pkg::RST_NS_PER_CM;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uer_pkg::CFG_ECHO_TIMEOUT: timeout_reg <= cfg_data[uer_pkg::TIMEOUT_BITS-1:0];
                uer_pkg::CFG_COUNTER_WRAP: wrap_reg    <= cfg_data[uer_pkg::STAMP_BITS-1:0];
                uer_pkg::CFG_TICK_NS:      tick_reg    <= cfg_data[uer_pkg::TICK_BITS-1:0];
                uer_pkg::CFG_NS_PER_CM:    nscm_reg    <= cfg_data[uer_pkg::NSCM_BITS-1:0];
                default:                   nscm_reg    <= nscm_reg;
            endcase
        end
    end

    uer_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .echo_timeout (timeout_reg),
        .counter_wrap (wrap_reg),
        .queue_full   (queue_full),
        .job_push     (job_push),
        .job          (push_job)
    );

    uer_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (job_pop),
        .avail    (job_avail),
        .pop_job  (pop_job)
    );

    uer_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (job_avail),
        .job       (pop_job),
        .job_pop   (job_pop),
        .tick_ns   (tick_reg),
        .ns_per_cm (nscm_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .busy      (back_busy)
    );

    `ASSERT_HOLDS(a_job_not_empty, job_push |-> ((push_job.trig | push_job.meas) != '0), "empty job queued")
    `ASSERT_NEVER(a_job_disjoint, job_push && ((push_job.trig & push_job.meas) != '0), "channel both triggers and ranges")
    `ASSERT_HOLDS(a_trigger_zero, (res_valid && res.kind == uer_pkg::KIND_TRIGGER) |-> (res.distance_cm == '0), "trigger with distance")
    `ASSERT_HOLDS(a_result_busy, res_valid |-> back_busy, "result outside a job")

endmodule
`default_nettype wire

>>> test/tb_ultrasonic_echo_ranger.sv
// Self-checking testbench for the three-channel ultrasonic echo ranger
module tb_ultrasonic_echo_ranger;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 200;

    class ranger_scoreboard;
        logic [uer_pkg::TIMEOUT_BITS-1:0] echo_timeout;
        logic [uer_pkg::STAMP_BITS-1:0]   counter_wrap;
        logic [uer_pkg::TICK_BITS-1:0]    tick_ns;
        logic [uer_pkg::NSCM_BITS-1:0]    ns_per_cm;
        logic [uer_pkg::STAMP_BITS-1:0]   rise_stamp [uer_pkg::SENSORS];
        logic [uer_pkg::STAMP_BITS-1:0]   fall_stamp [uer_pkg::SENSORS];
        bit                               expect_rise [uer_pkg::SENSORS];
        bit                               capture_pending [uer_pkg::SENSORS];
        bit                               waiting_echo [uer_pkg::SENSORS];
        logic [uer_pkg::TIMEOUT_BITS-1:0] wait_count [uer_pkg::SENSORS];
        uer_pkg::res_t                    pending_reports [$];
        int                               errors;

        function new();
            echo_timeout = uer_pkg::RST_ECHO_TIMEOUT;
            counter_wrap = uer_pkg::RST_COUNTER_WRAP;
            tick_ns      = uer_pkg::RST_TICK_NS;
            ns_per_cm    = uer_pkg::RST_NS_PER_CM;
            errors       = 0;
            for (int ch = 0; ch < uer_pkg::SENSORS; ch++)
            begin
                rise_stamp[ch]      = '0;
                fall_stamp[ch]      = '0;
                expect_rise[ch]     = 1'b1;
                capture_pending[ch] = 1'b0;
                waiting_echo[ch]    = 1'b0;
                wait_count[ch]      = '0;
            end
        endfunction

        function void write_reg(logic [uer_pkg::CFG_IDX_BITS-1:0] idx,
                                logic [uer_pkg::CFG_BITS-1:0] data);
            case (idx)
                uer_pkg::CFG_ECHO_TIMEOUT: echo_timeout = data[uer_pkg::TIMEOUT_BITS-1:0];
                uer_pkg::CFG_COUNTER_WRAP: counter_wrap = data[uer_pkg::STAMP_BITS-1:0];
                uer_pkg::CFG_TICK_NS:      tick_ns      = data[uer_pkg::TICK_BITS-1:0];
                uer_pkg::CFG_NS_PER_CM:    ns_per_cm    = data[uer_pkg::NSCM_BITS-1:0];
                default:                   ;
            endcase
        endfunction

        function logic [uer_pkg::DIST_BITS-1:0] range_cm(int ch);
            longint pulse;
            longint quotient;
            if (fall_stamp[ch] > rise_stamp[ch])
                pulse = longint'(fall_stamp[ch]) - longint'(rise_stamp[ch]);
            else
                pulse = longint'(counter_wrap) - longint'(rise_stamp[ch])
                        + longint'(fall_stamp[ch]);
            if (pulse < 0)
                return '0;
            if (ns_per_cm == 0)
                return '1;
            quotient = (pulse * longint'(tick_ns)) / longint'(ns_per_cm);
            if (quotient > 65535)
                return '1;
            return quotient[uer_pkg::DIST_BITS-1:0];
        endfunction

        function void predict_reports(uer_pkg::cmd_t c);
            uer_pkg::res_t batch [uer_pkg::SENSORS];
            int            n;
            int            ch;
            n = 0;
            if (c.action == uer_pkg::ACT_EDGE)
            begin
                if (c.channel >= uer_pkg::SENSORS)
                    return;
                ch = c.channel;
                if (expect_rise[ch])
                begin
                    rise_stamp[ch]  = c.stamp;
                    expect_rise[ch] = 1'b0;
                end
                else
                begin
                    fall_stamp[ch]      = c.stamp;
                    expect_rise[ch]     = 1'b1;
                    capture_pending[ch] = 1'b1;
                end
                return;
            end
            for (ch = 0; ch < uer_pkg::SENSORS; ch++)
            begin
                if (!waiting_echo[ch] || wait_count[ch] == echo_timeout)
                begin
                    waiting_echo[ch]     = 1'b1;
                    expect_rise[ch]      = 1'b1;
                    wait_count[ch]       = '0;
                    batch[n].sensor      = ch[uer_pkg::CH_BITS-1:0];
                    batch[n].kind        = uer_pkg::KIND_TRIGGER;
                    batch[n].distance_cm = '0;
                    batch[n].last        = 1'b0;
                    n++;
                end
                else if (capture_pending[ch])
                begin
                    capture_pending[ch]  = 1'b0;
                    waiting_echo[ch]     = 1'b0;
                    batch[n].sensor      = ch[uer_pkg::CH_BITS-1:0];
                    batch[n].kind        = uer_pkg::KIND_RANGE;
                    batch[n].distance_cm = range_cm(ch);
                    batch[n].last        = 1'b0;
                    n++;
                end
                else
                    wait_count[ch] = wait_count[ch] + 1'b1;
            end
            if (n > 0)
                batch[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
                pending_reports.push_back(batch[i]);
        endfunction

        function void check_report(uer_pkg::res_t r);
            uer_pkg::res_t e;
            if (pending_reports.size() == 0)
            begin
                $error("unexpected result: sensor %0d kind %0d distance_cm %0d last %0d",
                       r.sensor, r.kind, r.distance_cm, r.last);
                errors++;
                return;
            end
            e = pending_reports.pop_front();
            if (r.sensor !== e.sensor)
            begin
                $error("sensor: expected %0d, got %0d", e.sensor, r.sensor);
                errors++;
            end
            if (r.kind !== e.kind)
            begin
                $error("kind: expected %0d, got %0d", e.kind, r.kind);
                errors++;
            end
            if (r.distance_cm !== e.distance_cm)
            begin
                $error("distance_cm: expected %0d, got %0d", e.distance_cm, r.distance_cm);
                errors++;
            end
            if (r.last !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, r.last);
                errors++;
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cmd_valid;
    logic                             cmd_ready;
    uer_pkg::cmd_t                    cmd;
    logic                             res_valid;
    logic                             res_ready;
    uer_pkg::res_t                    res;
    logic                             cfg_we;
    logic [uer_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [uer_pkg::CFG_BITS-1:0]     cfg_data;

    ranger_scoreboard sb;
    bit               idle_en;
    int               cycles;

    ultrasonic_echo_ranger u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (cmd_valid && cmd_ready)
                sb.predict_reports(cmd);
            if (res_valid && res_ready)
                sb.check_report(res);
        end
    end

    initial
    begin
        res_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_en && $urandom_range(0, 5) == 0)
            begin
                res_ready = 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
            else
                res_ready = 1'b1;
        end
    end

    task automatic send_cmd(uer_pkg::cmd_t c);
        @(negedge clk);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            cmd_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        cmd       = c;
        cmd_valid = 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    task automatic send_edge(int ch, logic [uer_pkg::STAMP_BITS-1:0] stamp);
        uer_pkg::cmd_t c;
        c.action  = uer_pkg::ACT_EDGE;
        c.channel = ch[uer_pkg::CH_BITS-1:0];
        c.stamp   = stamp;
        send_cmd(c);
    endtask

    task automatic send_tick();
        uer_pkg::cmd_t c;
        c.action  = uer_pkg::ACT_TICK;
        c.channel = uer_pkg::CH_BITS'($urandom_range(0, 3));
        c.stamp   = uer_pkg::STAMP_BITS'($urandom);
        send_cmd(c);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        cmd_valid = 1'b0;
        while (sb.pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [uer_pkg::CFG_IDX_BITS-1:0] idx, int unsigned data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = uer_pkg::CFG_BITS'(data);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_regs(int unsigned timeout, int unsigned wrap, int unsigned tns,
                            int unsigned nscm);
        write_reg(uer_pkg::CFG_ECHO_TIMEOUT, timeout);
        write_reg(uer_pkg::CFG_COUNTER_WRAP, wrap);
        write_reg(uer_pkg::CFG_TICK_NS, tns);
        write_reg(uer_pkg::CFG_NS_PER_CM, nscm);
    endtask

    task automatic run_random(int count);
        int                             sent;
        logic [uer_pkg::STAMP_BITS-1:0] rise;
        logic [uer_pkg::STAMP_BITS-1:0] fall;
        uer_pkg::cmd_t                  c;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                send_tick();
                sent++;
                for (int ch = 0; ch < uer_pkg::SENSORS; ch++)
                begin
                    if ($urandom_range(0, 2) != 0)
                    begin
                        rise = uer_pkg::STAMP_BITS'($urandom);
                        case ($urandom_range(0, 3))
                            0:
                                fall = rise + uer_pkg::STAMP_BITS'($urandom_range(1, 2000));
                            1:
                                fall = rise;
                            2:
                                fall = uer_pkg::STAMP_BITS'($urandom);
                            default:
                                fall = rise - uer_pkg::STAMP_BITS'($urandom_range(1, 2000));
                        endcase
                        send_edge(ch, rise);
                        send_edge(ch, fall);
                        sent += 2;
                    end
                end
            end
            else
            begin
                c.action  = 1'($urandom_range(0, 1));
                c.channel = uer_pkg::CH_BITS'($urandom_range(0, 3));
                c.stamp   = uer_pkg::STAMP_BITS'($urandom);
                send_cmd(c);
                sent++;
            end
        end
    endtask

    initial
    begin
        uer_pkg::cmd_t c;
        sb        = new();
        idle_en   = 1'b1;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_edge(3, 16'h5A5A);
        send_tick();
        send_tick();
        send_edge(0, 16'h0000);
        send_edge(0, 16'hFFFF);
        send_edge(1, 16'h1234);
        send_edge(1, 16'h1234);
        send_edge(2, 16'hFFFF);
        send_edge(2, 16'h0000);
        c.action  = uer_pkg::ACT_TICK;
        c.channel = 2'd3;
        c.stamp   = 16'hFFFF;
        send_cmd(c);
        send_edge(0, 16'd100);
        send_edge(0, 16'd5000);
        send_edge(1, 16'd700);
        send_tick();
        send_tick();
        send_tick();
        wait_idle();

        set_regs(255, 65535, 65535, 1);
        run_random(10);
        wait_idle();

        set_regs(1, 1, 1, 20'hFFFFF);
        run_random(10);
        wait_idle();

        set_regs(0, 49151, 2667, 0);
        run_random(10);
        wait_idle();

        for (int p = 0; p < 3; p++)
        begin
            if (p == 2)
                idle_en = 1'b0;
            set_regs($urandom_range(1, 255), $urandom_range(1, 65535),
                     $urandom_range(1, 65535), $urandom_range(1, 1048575));
            run_random(20);
            wait_idle();
        end

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> ultrasonic_echo_ranger.f
+incdir+rtl
rtl/uer_pkg.sv
rtl/uer_queue.sv
rtl/uer_front.sv
rtl/uer_div.sv
rtl/uer_back.sv
rtl/ultrasonic_echo_ranger.sv
test/tb_ultrasonic_echo_ranger.sv
